// File: rtl/pose_to_twist_estimator_defines.svh
// ----------------------------------------------------------------------------
// Pose-to-twist estimator assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef POSE_TO_TWIST_ESTIMATOR_DEFINES_SVH
`define POSE_TO_TWIST_ESTIMATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/pte_pkg.sv
// ----------------------------------------------------------------------------
// Pose-to-twist estimator package
// Types, command codes, constants and helper functions shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pte_pkg;

	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 62;
	localparam int RATE_W    = 40;
	localparam int AXIS_W    = 61;
	localparam int ACC_W     = AXIS_W + RATE_W;
	localparam int MAG_W     = ACC_W - 28;

	localparam logic [19:0] USEC_PER_S = 20'd1000000;
	localparam logic signed [33:0] PI_HALF_Q30 = 34'sd1686629713;
	localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
	localparam logic [28:0] ONE_Q28 = 29'd268435456;

	localparam logic [5:0] SQRT_LAST   = 6'd28;
	localparam logic [5:0] CORDIC_LAST = 6'd29;
	localparam logic [5:0] AMUL_LAST   = 6'd39;

	localparam logic [1:0] ST_VALID  = 2'd0;
	localparam logic [1:0] ST_FIRST  = 2'd1;
	localparam logic [1:0] ST_NONPOS = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_LOAD,
		OP_CHECK,
		OP_LIN_START,
		OP_LIN_STORE,
		OP_DQ,
		OP_CLAMP,
		OP_S2,
		OP_SQRT,
		OP_CORDIC_INIT,
		OP_CORDIC,
		OP_RATE_START,
		OP_RATE_STORE,
		OP_AXIS_START,
		OP_AXIS_STORE,
		OP_AMUL,
		OP_ANG_STORE,
		OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] idx;
		logic [5:0] step;
	} cmd_t;

	typedef struct packed {
		logic first;
		logic nonpos;
		logic s2_zero;
		logic div_done;
	} stat_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd843314856;
			5'd1:  r = 30'd497837829;
			5'd2:  r = 30'd263043836;
			5'd3:  r = 30'd133525158;
			5'd4:  r = 30'd67021686;
			5'd5:  r = 30'd33543515;
			5'd6:  r = 30'd16775850;
			5'd7:  r = 30'd8388437;
			5'd8:  r = 30'd4194282;
			5'd9:  r = 30'd2097149;
			5'd10: r = 30'd1048575;
			5'd11: r = 30'd524287;
			5'd12: r = 30'd262143;
			5'd13: r = 30'd131071;
			5'd14: r = 30'd65535;
			5'd15: r = 30'd32767;
			5'd16: r = 30'd16383;
			5'd17: r = 30'd8191;
			5'd18: r = 30'd4095;
			5'd19: r = 30'd2047;
			5'd20: r = 30'd1023;
			5'd21: r = 30'd511;
			5'd22: r = 30'd255;
			5'd23: r = 30'd127;
			5'd24: r = 30'd63;
			5'd25: r = 30'd31;
			5'd26: r = 30'd15;
			5'd27: r = 30'd7;
			5'd28: r = 30'd3;
			5'd29: r = 30'd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Applies a sign to a magnitude and saturates to a signed 32-bit word.
	function automatic logic signed [31:0] sat32(input logic neg, input logic [MAG_W-1:0] m);
		logic signed [31:0] r;
		if (neg) begin
			r = (m > MAG_W'(33'h080000000)) ? 32'sh80000000 : -$signed(m[31:0]);
		end else begin
			r = (m > MAG_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(m[31:0]);
		end
		return r;
	endfunction

endpackage

// File: rtl/pte_pose_if.sv
// ----------------------------------------------------------------------------
// Pose channel
// Valid/ready channel carrying one timestamped pose word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pte_pose_if;
	logic               valid;
	logic               ready;
	logic        [47:0] stamp_us;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [15:0] quat_x;
	logic signed [15:0] quat_y;
	logic signed [15:0] quat_z;
	logic signed [15:0] quat_w;

	modport source (output valid, stamp_us, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
		quat_w, input ready);
	modport sink (input valid, stamp_us, pos_x, pos_y, pos_z, quat_x, quat_y, quat_z,
		quat_w, output ready);
endinterface

// File: rtl/pte_twist_if.sv
// ----------------------------------------------------------------------------
// Twist channel
// Valid/ready channel carrying one velocity estimate word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pte_twist_if;
	logic               valid;
	logic               ready;
	logic        [47:0] out_stamp_us;
	logic signed [31:0] lin_vel_x;
	logic signed [31:0] lin_vel_y;
	logic signed [31:0] lin_vel_z;
	logic signed [31:0] ang_vel_x;
	logic signed [31:0] ang_vel_y;
	logic signed [31:0] ang_vel_z;
	logic        [1:0]  status;

	modport source (output valid, out_stamp_us, lin_vel_x, lin_vel_y, lin_vel_z, ang_vel_x,
		ang_vel_y, ang_vel_z, status, input ready);
	modport sink (input valid, out_stamp_us, lin_vel_x, lin_vel_y, lin_vel_z, ang_vel_x,
		ang_vel_y, ang_vel_z, status, output ready);
endinterface

// File: rtl/pte_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pte_pkg::DIV_NUM_W-1:0] dividend,
	input  logic [pte_pkg::DIV_DEN_W-1:0] divisor,
	output logic                          done,
	output logic [pte_pkg::DIV_NUM_W-1:0] quotient
);
	import pte_pkg::*;

	localparam int CNT_W = $clog2(DIV_NUM_W + 1);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   rem_sh;
	logic                 fits;
	logic                 last_step;

	assign rem_sh    = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits      = rem_sh >= {1'b0, den_q};
	assign last_step = busy_q && (cnt_q == CNT_W'(DIV_NUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_step;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end else if (start) begin
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/pte_dp.sv
// ----------------------------------------------------------------------------
// Pose-to-twist datapath
// Pose storage, quaternion difference, square root, CORDIC, shared divider,
// serial multiplier and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  pte_pkg::cmd_t      cmd,
	output pte_pkg::stat_t     stat,
	input  logic        [47:0] stamp_us,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic        [47:0] out_stamp_us,
	output logic signed [31:0] lin_vel_x,
	output logic signed [31:0] lin_vel_y,
	output logic signed [31:0] lin_vel_z,
	output logic signed [31:0] ang_vel_x,
	output logic signed [31:0] ang_vel_y,
	output logic signed [31:0] ang_vel_z,
	output logic        [1:0]  status
);
	import pte_pkg::*;

	logic        [47:0] cur_stamp_q, prev_stamp_q, dt_q;
	logic signed [31:0] cur_pos_q [3];
	logic signed [31:0] prev_pos_q [3];
	logic signed [15:0] cur_quat_q [4];
	logic signed [15:0] prev_quat_q [4];
	logic               have_prev_q;
	logic        [1:0]  code_q;
	logic signed [31:0] vel_q [6];
	logic signed [33:0] dq_q [4];
	logic        [28:0] wm_q;
	logic               w_neg_q;
	logic        [56:0] s2_q;
	logic        [31:0] sq_rem_q;
	logic        [28:0] sq_root_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [RATE_W-1:0]  rate_q;
	logic [AXIS_W-1:0]  axis_q;
	logic               neg_q;
	logic [ACC_W-1:0]   acc_q;
	logic        [47:0] out_stamp_q;
	logic signed [31:0] out_vel_q [6];
	logic        [1:0]  out_code_q;

	logic                 div_start, div_done;
	logic [DIV_NUM_W-1:0] div_num, div_quo;
	logic [DIV_DEN_W-1:0] div_den;

	// Quaternion difference operands, one component per command.
	logic signed [15:0] qa [4];
	logic signed [15:0] pb [4];
	logic               ng [4];
	logic signed [31:0] prod [4];
	logic signed [33:0] dq_sum;

	always_comb begin
		qa = '{cur_quat_q[3], cur_quat_q[0], cur_quat_q[1], cur_quat_q[2]};
		case (cmd.idx)
			2'd0: begin
				pb = '{prev_quat_q[0], prev_quat_q[3], prev_quat_q[2], prev_quat_q[1]};
				ng = '{1'b1, 1'b0, 1'b1, 1'b0};
			end
			2'd1: begin
				pb = '{prev_quat_q[1], prev_quat_q[2], prev_quat_q[3], prev_quat_q[0]};
				ng = '{1'b1, 1'b0, 1'b0, 1'b1};
			end
			2'd2: begin
				pb = '{prev_quat_q[2], prev_quat_q[1], prev_quat_q[0], prev_quat_q[3]};
				ng = '{1'b1, 1'b1, 1'b0, 1'b0};
			end
			default: begin
				pb = '{prev_quat_q[3], prev_quat_q[0], prev_quat_q[1], prev_quat_q[2]};
				ng = '{1'b0, 1'b0, 1'b0, 1'b0};
			end
		endcase
		dq_sum = '0;
		for (int i = 0; i < 4; i++) begin
			prod[i] = qa[i] * pb[i];
			dq_sum  = ng[i] ? dq_sum - 34'(prod[i]) : dq_sum + 34'(prod[i]);
		end
	end

	// Clamp of the difference scalar to one.
	logic signed [33:0] w_abs;
	logic        [28:0] wm_next;
	assign w_abs   = dq_q[3] < 0 ? -dq_q[3] : dq_q[3];
	assign wm_next = (w_abs > 34'(ONE_Q28)) ? ONE_Q28 : w_abs[28:0];

	logic [57:0] wsq;
	assign wsq = 58'(wm_q) * 58'(wm_q);

	// Square root, two radicand bits per step from the top.
	logic [57:0] s2_pad;
	logic [4:0]  pair;
	logic [31:0] rem_sh, trial;
	assign s2_pad = {1'b0, s2_q};
	assign pair   = 5'(5'd28 - cmd.step[4:0]);
	assign rem_sh = {sq_rem_q[29:0], s2_pad[{pair, 1'b0} +: 2]};
	assign trial  = {1'b0, sq_root_q, 2'b01};

	// CORDIC step.
	logic signed [33:0] xs, ys, at;
	assign xs = cx_q >>> cmd.step[4:0];
	assign ys = cy_q >>> cmd.step[4:0];
	assign at = 34'(atan_q30(cmd.step[4:0]));

	logic signed [33:0] cw;
	assign cw = w_neg_q ? -34'(wm_q) : 34'(wm_q);

	logic [31:0] zc;
	logic [52:0] angle_us;
	always_comb begin
		if (cz_q < 0) zc = '0;
		else if (cz_q > PI_Q30) zc = PI_Q30[31:0];
		else zc = cz_q[31:0];
		angle_us = 53'({zc, 1'b0}) * 53'(USEC_PER_S);
	end

	// Translation difference scaled to microseconds.
	logic signed [32:0] d;
	logic        [32:0] dmag;
	logic        [52:0] d_us;
	always_comb begin
		d    = 33'(cur_pos_q[cmd.idx]) - 33'(prev_pos_q[cmd.idx]);
		dmag = d < 0 ? 33'(-d) : 33'(d);
		d_us = 53'(dmag) * 53'(USEC_PER_S);
	end

	logic signed [33:0] v;
	logic        [32:0] vmag;
	assign v    = dq_q[cmd.idx];
	assign vmag = v < 0 ? 33'(-v) : 33'(v);

	logic [2:0] ang_idx;
	assign ang_idx = 3'(3'd3 + 3'(cmd.idx));

	always_comb begin
		div_start = 1'b0;
		div_num   = 64'(d_us);
		div_den   = DIV_DEN_W'(dt_q);
		case (cmd.op)
			OP_LIN_START: div_start = 1'b1;
			OP_RATE_START: begin
				div_start = 1'b1;
				div_num   = 64'(angle_us);
				div_den   = {dt_q, 14'b0};
			end
			OP_AXIS_START: begin
				div_start = 1'b1;
				div_num   = 64'({vmag, 28'b0});
				div_den   = DIV_DEN_W'(sq_root_q);
			end
			default: ;
		endcase
	end

	pte_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	logic amul_bit;
	assign amul_bit = rate_q[6'(6'd39 - cmd.step)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q <= 1'b0;
		end else if (cmd.op == OP_COMMIT) begin
			have_prev_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cur_stamp_q <= stamp_us;
				cur_pos_q   <= '{pos_x, pos_y, pos_z};
				cur_quat_q  <= '{quat_x, quat_y, quat_z, quat_w};
			end
			OP_CHECK: begin
				dt_q <= cur_stamp_q - prev_stamp_q;
				for (int i = 0; i < 6; i++) vel_q[i] <= '0;
				if (!have_prev_q) code_q <= ST_FIRST;
				else if (cur_stamp_q <= prev_stamp_q) code_q <= ST_NONPOS;
				else code_q <= ST_VALID;
			end
			OP_LIN_START: neg_q <= d < 0;
			OP_LIN_STORE: vel_q[cmd.idx] <= sat32(neg_q, MAG_W'(div_quo));
			OP_DQ: dq_q[cmd.idx] <= dq_sum;
			OP_CLAMP: begin
				wm_q    <= wm_next;
				w_neg_q <= dq_q[3] < 0;
			end
			OP_S2: begin
				s2_q      <= 57'((58'd1 << 56) - wsq);
				sq_rem_q  <= '0;
				sq_root_q <= '0;
			end
			OP_SQRT: begin
				if (rem_sh >= trial) begin
					sq_rem_q  <= rem_sh - trial;
					sq_root_q <= {sq_root_q[27:0], 1'b1};
				end else begin
					sq_rem_q  <= rem_sh;
					sq_root_q <= {sq_root_q[27:0], 1'b0};
				end
			end
			OP_CORDIC_INIT: begin
				// A negative scalar is turned by a quarter turn first.
				if (w_neg_q) begin
					cx_q <= 34'(sq_root_q);
					cy_q <= 34'(wm_q);
					cz_q <= PI_HALF_Q30;
				end else begin
					cx_q <= cw;
					cy_q <= 34'(sq_root_q);
					cz_q <= '0;
				end
			end
			OP_CORDIC: begin
				if (cy_q > 0) begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					cz_q <= cz_q + at;
				end else if (cy_q < 0) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					cz_q <= cz_q - at;
				end
			end
			OP_RATE_STORE: rate_q <= div_quo[RATE_W-1:0];
			OP_AXIS_START: neg_q <= v < 0;
			OP_AXIS_STORE: begin
				acc_q <= '0;
				if (s2_q == '0) begin
					// With no rotation left the axis is taken along x.
					axis_q <= (cmd.idx == 2'd0) ? AXIS_W'(ONE_Q28) : '0;
					neg_q  <= 1'b0;
				end else begin
					axis_q <= div_quo[AXIS_W-1:0];
				end
			end
			OP_AMUL: acc_q <= {acc_q[ACC_W-2:0], 1'b0} + (amul_bit ? ACC_W'(axis_q) : '0);
			OP_ANG_STORE: vel_q[ang_idx] <= sat32(neg_q, acc_q[ACC_W-1:28]);
			OP_COMMIT: begin
				prev_stamp_q <= cur_stamp_q;
				prev_pos_q   <= cur_pos_q;
				prev_quat_q  <= cur_quat_q;
				out_stamp_q  <= cur_stamp_q;
				out_vel_q    <= vel_q;
				out_code_q   <= code_q;
			end
			default: ;
		endcase
	end

	assign stat.first    = !have_prev_q;
	assign stat.nonpos   = cur_stamp_q <= prev_stamp_q;
	assign stat.s2_zero  = s2_q == '0;
	assign stat.div_done = div_done;

	assign out_stamp_us = out_stamp_q;
	assign lin_vel_x    = out_vel_q[0];
	assign lin_vel_y    = out_vel_q[1];
	assign lin_vel_z    = out_vel_q[2];
	assign ang_vel_x    = out_vel_q[3];
	assign ang_vel_y    = out_vel_q[4];
	assign ang_vel_z    = out_vel_q[5];
	assign status       = out_code_q;
endmodule

// File: rtl/pte_ctrl.sv
// ----------------------------------------------------------------------------
// Pose-to-twist controller
// Sequences the datapath through one pose word and owns both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pte_pkg::stat_t stat,
	output pte_pkg::cmd_t  cmd
);
	import pte_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_LIN, S_LIN_WAIT, S_LIN_ST, S_DQ, S_CLAMP, S_S2, S_SQRT,
		S_CINIT, S_CORDIC, S_RATE, S_RATE_WAIT, S_RATE_ST, S_AXIS, S_AXIS_WAIT,
		S_AXIS_ST, S_AMUL, S_ANG_ST, S_DONE
	} state_t;

	state_t     state_q;
	logic [5:0] cnt_q;
	logic [1:0] k_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_CHECK;
				S_CHECK: begin
					k_q     <= '0;
					state_q <= (stat.first || stat.nonpos) ? S_DONE : S_LIN;
				end
				S_LIN:      state_q <= S_LIN_WAIT;
				S_LIN_WAIT: if (stat.div_done) state_q <= S_LIN_ST;
				S_LIN_ST: begin
					if (k_q == 2'd2) begin
						k_q     <= '0;
						state_q <= S_DQ;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LIN;
					end
				end
				S_DQ: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) state_q <= S_CLAMP;
				end
				S_CLAMP: state_q <= S_S2;
				S_S2: begin
					cnt_q   <= '0;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == SQRT_LAST) state_q <= S_CINIT;
				end
				S_CINIT: begin
					cnt_q   <= '0;
					state_q <= S_CORDIC;
				end
				S_CORDIC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CORDIC_LAST) state_q <= S_RATE;
				end
				S_RATE:      state_q <= S_RATE_WAIT;
				S_RATE_WAIT: if (stat.div_done) state_q <= S_RATE_ST;
				S_RATE_ST: begin
					k_q     <= '0;
					state_q <= S_AXIS;
				end
				S_AXIS:      state_q <= stat.s2_zero ? S_AXIS_ST : S_AXIS_WAIT;
				S_AXIS_WAIT: if (stat.div_done) state_q <= S_AXIS_ST;
				S_AXIS_ST: begin
					cnt_q   <= '0;
					state_q <= S_AMUL;
				end
				S_AMUL: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == AMUL_LAST) state_q <= S_ANG_ST;
				end
				S_ANG_ST: begin
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == 2'd2) ? S_DONE : S_AXIS;
				end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.idx  = k_q;
		cmd.step = cnt_q;
		unique case (state_q)
			S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NOP;
			S_CHECK:   cmd.op = OP_CHECK;
			S_LIN:     cmd.op = OP_LIN_START;
			S_LIN_ST:  cmd.op = OP_LIN_STORE;
			S_DQ:      cmd.op = OP_DQ;
			S_CLAMP:   cmd.op = OP_CLAMP;
			S_S2:      cmd.op = OP_S2;
			S_SQRT:    cmd.op = OP_SQRT;
			S_CINIT:   cmd.op = OP_CORDIC_INIT;
			S_CORDIC:  cmd.op = OP_CORDIC;
			S_RATE:    cmd.op = OP_RATE_START;
			S_RATE_ST: cmd.op = OP_RATE_STORE;
			S_AXIS:    cmd.op = stat.s2_zero ? OP_NOP : OP_AXIS_START;
			S_AXIS_ST: cmd.op = OP_AXIS_STORE;
			S_AMUL:    cmd.op = OP_AMUL;
			S_ANG_ST:  cmd.op = OP_ANG_STORE;
			S_DONE:    cmd.op = out_free ? OP_COMMIT : OP_NOP;
			default:   cmd.op = OP_NOP;
		endcase
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
endmodule

// File: rtl/pose_to_twist_estimator.sv
// ----------------------------------------------------------------------------
// Pose-to-twist estimator
// Finite-difference linear and angular velocity from timestamped poses.
// ----------------------------------------------------------------------------
// Each pose word yields exactly one twist word. The first pose after reset,
// or a pose whose stamp does not advance, is only stored and returns zero
// velocity with a status code. For a regular pose the shared 64-step divider
// runs seven times (three linear components, the angle rate and three axis
// components), the square root takes 29 steps, the CORDIC 30 steps and each
// axis-rate product 40 steps of a serial multiplier. When no rotation sine is
// left the three axis divisions are skipped. A finished result waits while
// the previous word is still unread, and the next pose is accepted in the
// cycle after the result is loaded into the output register.
`timescale 1ns / 1ps
`include "pose_to_twist_estimator_defines.svh"

module pose_to_twist_estimator (
	input logic          clk,
	input logic          arst_n,
	pte_pose_if.sink     pose,
	pte_twist_if.source  twist
);
	import pte_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pose.valid),
		.in_ready  (pose.ready),
		.out_valid (twist.valid),
		.out_ready (twist.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pte_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.stamp_us     (pose.stamp_us),
		.pos_x        (pose.pos_x),
		.pos_y        (pose.pos_y),
		.pos_z        (pose.pos_z),
		.quat_x       (pose.quat_x),
		.quat_y       (pose.quat_y),
		.quat_z       (pose.quat_z),
		.quat_w       (pose.quat_w),
		.out_stamp_us (twist.out_stamp_us),
		.lin_vel_x    (twist.lin_vel_x),
		.lin_vel_y    (twist.lin_vel_y),
		.lin_vel_z    (twist.lin_vel_z),
		.ang_vel_x    (twist.ang_vel_x),
		.ang_vel_y    (twist.ang_vel_y),
		.ang_vel_z    (twist.ang_vel_z),
		.status       (twist.status)
	);

	`PTE_ASSERT_NEXT(a_one_in_flight, clk, arst_n, pose.valid && pose.ready, !pose.ready, "pose accepted while another is in work")
	`PTE_ASSERT_SAME(a_valid_after_commit, clk, arst_n, $rose(twist.valid), $past(cmd.op == OP_COMMIT), "twist word raised without a commit")
	`PTE_ASSERT_SAME(a_load_only_idle, clk, arst_n, cmd.op == OP_LOAD, pose.ready && pose.valid, "pose loaded outside a handshake")
endmodule
